// ===== rtl/zd_pkg.sv =====
// shared constants, types and the fibonacci table of the zeckendorf decomposer
package zd_pkg;

   localparam int VALUE_BITS  = 20;
   localparam int POS_BITS    = 5;
   localparam int MAX_RESULTS = 15;
   localparam int QUEUE_DEPTH = 2;

   // number of distinct fibonacci numbers 1, 2, 3, 5, ... that fit in VALUE_BITS
   function automatic int count_fib();
      longint unsigned prev;
      longint unsigned cur;
      longint unsigned nxt;
      longint unsigned mask;
      int              n;
      prev = 64'd1;
      cur  = 64'd1;
      mask = (64'd1 << VALUE_BITS) - 64'd1;
      n    = 0;
      while (cur <= mask) begin
         nxt  = prev + cur;
         prev = cur;
         cur  = nxt;
         n++;
      end
      return n;
   endfunction

   localparam int FIB_COUNT = count_fib();
   localparam int IDX_BITS  = $clog2(FIB_COUNT);
   localparam int CNT_BITS  = $clog2(MAX_RESULTS + 1);

   typedef logic [VALUE_BITS-1:0] fib_table_type [FIB_COUNT];

   function automatic fib_table_type build_fib_table();
      fib_table_type   tab;
      longint unsigned prev;
      longint unsigned cur;
      longint unsigned nxt;
      prev = 64'd1;
      cur  = 64'd1;
      for (int i = 0; i < FIB_COUNT; i++) begin
         tab[i] = cur[VALUE_BITS-1:0];
         nxt    = prev + cur;
         prev   = cur;
         cur    = nxt;
      end
      return tab;
   endfunction

   localparam fib_table_type FIB_TABLE = build_fib_table();

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_WALK
   } back_state_type;

endpackage

// ===== rtl/zd_front.sv =====
// request front end: accepts values and drops zeros before the queue
module zd_front
   import zd_pkg::*;
(
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_BITS-1:0] req_value,
   input  queue_status_type      queue_status,
   output logic                  push,
   output logic [VALUE_BITS-1:0] push_value
);

   logic accept;

   always_comb begin
      busy       = queue_status.full;
      accept     = start && !queue_status.full;
      // a zero value has no terms, so it never reaches the walker
      push       = accept && (req_value != '0);
      push_value = req_value;
   end

endmodule

// ===== rtl/zd_queue.sv =====
// short fifo of pending values between the front end and the walker
module zd_queue
   import zd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [VALUE_BITS-1:0] push_value,
   input  logic                  pop,
   output logic [VALUE_BITS-1:0] head_value,
   output queue_status_type      status
);

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [VALUE_BITS-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
      if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_BITS'(1);
   endfunction

   always_comb begin
      status.full  = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      head_value   = slot_ff[rd_ptr_ff];
      wr_ptr_in    = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in    = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in     = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_value;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !(status.full && status.empty))
      else $error("queue reports full and empty together");

   assert property (@(posedge clock) disable iff (reset)
      (push && status.full && !pop) |=> $stable(count_ff))
      else $error("queue count moved on a push into a full queue");

endmodule

// ===== rtl/zd_back.sv =====
// walker: compares the remainder with one table entry per cycle and emits terms
module zd_back
   import zd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  queue_status_type      queue_status,
   input  logic [VALUE_BITS-1:0] head_value,
   output logic                  pop,
   output logic                  rsp_valid,
   output logic [VALUE_BITS-1:0] rsp_term,
   output logic [POS_BITS-1:0]   rsp_position,
   output logic                  rsp_last
);

   back_state_type        state_ff, state_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  valid_ff, valid_in;
   logic [VALUE_BITS-1:0] term_ff, term_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic                  last_ff, last_in;

   logic [VALUE_BITS-1:0] entry;
   logic [VALUE_BITS-1:0] rem_next;
   logic                  take;
   logic                  done;

   always_comb begin
      entry    = FIB_TABLE[idx_ff];
      take     = (rem_ff >= entry);
      rem_next = take ? (rem_ff - entry) : rem_ff;
      // stop on a cleared remainder, the smallest entry or the term limit
      done     = (rem_next == '0) || (idx_ff == '0)
                 || (take && (cnt_ff == CNT_BITS'(MAX_RESULTS - 1)));

      state_in = state_ff;
      rem_in   = rem_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      pop      = 1'b0;
      valid_in = 1'b0;
      term_in  = entry;
      pos_in   = POS_BITS'(idx_ff);
      last_in  = (rem_next == '0);

      unique case (state_ff)
         BACK_IDLE: begin
            if (!queue_status.empty) begin
               pop      = 1'b1;
               rem_in   = head_value;
               idx_in   = IDX_BITS'(FIB_COUNT - 1);
               cnt_in   = '0;
               state_in = BACK_WALK;
            end
         end
         BACK_WALK: begin
            valid_in = take;
            rem_in   = rem_next;
            cnt_in   = cnt_ff + CNT_BITS'(take);
            // the index stays inside the table once the walk ends
            if (done) begin
               state_in = BACK_IDLE;
            end else begin
               idx_in = idx_ff - IDX_BITS'(1);
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         rem_ff   <= '0;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rem_ff   <= rem_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      term_ff <= term_in;
      pos_ff  <= pos_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_term     = term_ff;
   assign rsp_position = pos_ff;
   assign rsp_last     = last_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_term != '0))
      else $error("zero term emitted");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("term emitted straight after the last term of a value");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_WALK) |-> (rem_ff != '0))
      else $error("walker running with nothing left to cover");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == BACK_IDLE && !queue_status.empty))
      else $error("queue popped while walking or empty");

endmodule

// ===== rtl/zeckendorf_decomposer_core.sv =====
// top level of the zeckendorf decomposer: front end, request queue and walker
//
// A request is taken on a rising edge with start high and busy low; a request
// of zero yields no terms. Each nonzero value comes out as its Zeckendorf
// terms, largest first, one per rsp_valid cycle, with rsp_position giving the
// table place (0 for 1, 1 for 2, ...) and rsp_last marking the final term.
// The receiver cannot stall: every rsp_valid cycle must be taken. A value
// leaves the queue into the walker, which compares and subtracts one table
// entry per cycle, from the largest entry down to the one that clears the
// remainder; it takes the next value only once that walk ends. A two-entry
// queue sits in front of the walker, and busy is high only while that queue
// is full.
module zeckendorf_decomposer_core
   import zd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   output logic [VALUE_BITS-1:0] rsp_term,
   output logic [POS_BITS-1:0]   rsp_position,
   output logic                  rsp_last
);

   queue_status_type      queue_status;
   logic                  push;
   logic [VALUE_BITS-1:0] push_value;
   logic                  pop;
   logic [VALUE_BITS-1:0] head_value;

   zd_front u_front (
      .start        (start),
      .busy         (busy),
      .req_value    (req_value),
      .queue_status (queue_status),
      .push         (push),
      .push_value   (push_value)
   );

   zd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_value (push_value),
      .pop        (pop),
      .head_value (head_value),
      .status     (queue_status)
   );

   zd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head_value   (head_value),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_term     (rsp_term),
      .rsp_position (rsp_position),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for zeckendorf_decomposer_core: queued requests, term predictor, checker
`timescale 1ns / 1ps

module testbench
   import zd_pkg::*;
();

   localparam int CLK_HALF      = 4;
   localparam int TABLE_MAX     = 32;
   localparam int RANDOM_ITEMS  = 260;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_REPORTS   = 40;

   typedef struct {
      logic [VALUE_BITS-1:0] value;
      bit                    drain;
   } request_rec_type;

   typedef struct {
      logic [VALUE_BITS-1:0] term;
      logic [POS_BITS-1:0]   position;
      logic                  last;
   } term_rec_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic                  busy;
   logic                  rsp_valid;
   logic [VALUE_BITS-1:0] rsp_term;
   logic [POS_BITS-1:0]   rsp_position;
   logic                  rsp_last;

   request_rec_type       pending_requests[$];
   term_rec_type          expected_terms[$];
   logic [VALUE_BITS-1:0] fib_numbers[TABLE_MAX];
   int                    fib_total = 0;
   int                    error_count = 0;
   int                    burst_left = 4;
   int                    gap_left = 0;

   zeckendorf_decomposer_core DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_term     (rsp_term),
      .rsp_position (rsp_position),
      .rsp_last     (rsp_last)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // greedy walk from the largest fibonacci number down, capped at the term limit
   function automatic void predict_terms(input logic [VALUE_BITS-1:0] value);
      logic [VALUE_BITS-1:0] rest;
      term_rec_type          rec;
      int                    n_terms;
      rest    = value;
      n_terms = 0;
      for (int i = fib_total - 1; i >= 0; i--) begin
         if (rest == '0 || n_terms == MAX_RESULTS)
            break;
         if (rest >= fib_numbers[i]) begin
            rest         = rest - fib_numbers[i];
            rec.term     = fib_numbers[i];
            rec.position = i[POS_BITS-1:0];
            rec.last     = (rest == '0);
            expected_terms = {expected_terms, rec};
            n_terms++;
         end
      end
   endfunction

   // random sum of non-adjacent fibonacci numbers, so the walk skips in odd patterns
   function automatic logic [VALUE_BITS-1:0] random_fib_sum();
      longint unsigned acc;
      int              i;
      acc = 0;
      i   = fib_total - 1;
      while (i >= 0) begin
         if ($urandom_range(0, 2) == 0 && acc + fib_numbers[i] < (64'd1 << VALUE_BITS)) begin
            acc += fib_numbers[i];
            i   -= 2;
         end else begin
            i--;
         end
      end
      return acc[VALUE_BITS-1:0];
   endfunction

   function automatic void queue_request(input logic [VALUE_BITS-1:0] value, input bit drain);
      request_rec_type rec;
      rec.value = value;
      rec.drain = drain;
      pending_requests = {pending_requests, rec};
   endfunction

   // sender: bursts of requests separated by random gaps
   always @(posedge clock) begin
      request_rec_type nxt;
      if (reset) begin
         start     <= 1'b0;
         req_value <= '0;
      end else if (!start || !busy) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
         end else if (pending_requests.size() != 0 &&
                      !(pending_requests[0].drain &&
                        (start || expected_terms.size() != 0))) begin
            nxt       = pending_requests.pop_front();
            start     <= 1'b1;
            req_value <= nxt.value;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(0, 3) == 0 ? $urandom_range(20, 40)
                                                       : $urandom_range(1, 8);
               gap_left   <= $urandom_range(1, 35);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: predict on each accepted request, check each term strobe
   always @(posedge clock) begin
      term_rec_type want;
      if (!reset) begin
         if (start && !busy)
            predict_terms(req_value);
         if (rsp_valid) begin
            if (expected_terms.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: unexpected term: expected none, got term %0d %s",
                           $time, rsp_term,
                           $sformatf("position %0d last %0b", rsp_position, rsp_last));
            end else begin
               want = expected_terms.pop_front();
               if (rsp_term !== want.term) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("%0t: term expected %0d, got %0d", $time, want.term, rsp_term);
               end
               if (rsp_position !== want.position) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("%0t: position expected %0d, got %0d",
                              $time, want.position, rsp_position);
               end
               if (rsp_last !== want.last) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("%0t: last expected %0b, got %0b", $time, want.last, rsp_last);
               end
            end
         end
      end
   end

   initial begin
      longint unsigned prev;
      longint unsigned cur;
      longint unsigned nxt;
      logic [VALUE_BITS-1:0] v;
      int                    pick;

      prev = 1;
      cur  = 1;
      while (cur < (64'd1 << VALUE_BITS) && fib_total < TABLE_MAX) begin
         fib_numbers[fib_total] = cur[VALUE_BITS-1:0];
         fib_total++;
         nxt  = prev + cur;
         prev = cur;
         cur  = nxt;
      end

      // directed: zero, smallest values, the top of the range and table, bit patterns
      queue_request('0, 1'b0);
      queue_request(20'd1, 1'b0);
      queue_request(20'd2, 1'b0);
      queue_request(20'd3, 1'b0);
      queue_request(20'd4, 1'b0);
      queue_request(20'd12, 1'b0);
      queue_request(20'hFFFFF, 1'b0);
      queue_request(fib_numbers[fib_total-1], 1'b0);
      queue_request(fib_numbers[fib_total-1] - 20'd1, 1'b0);
      queue_request(fib_numbers[fib_total-1] + 20'd1, 1'b0);
      queue_request(fib_numbers[fib_total-2], 1'b0);
      queue_request(fib_numbers[fib_total-2] - 20'd1, 1'b0);
      queue_request(20'h55555, 1'b0);
      queue_request(20'hAAAAA, 1'b0);
      queue_request(20'h80000, 1'b0);
      queue_request(20'h00001, 1'b0);
      queue_request(20'd6765, 1'b0);
      queue_request('0, 1'b0);
      queue_request(20'hFFFFE, 1'b0);
      queue_request(20'd100, 1'b1);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2, 3: v = VALUE_BITS'($urandom_range(0, 20'hFFFFF));
            4, 5:       v = random_fib_sum();
            6:          v = VALUE_BITS'($urandom_range(0, 200));
            7:          v = VALUE_BITS'(fib_numbers[$urandom_range(0, fib_total - 1)]
                                        + $urandom_range(0, 2) - 1);
            8:          v = VALUE_BITS'(20'hFFFFF - $urandom_range(0, 300));
            default:    v = '0;
         endcase
         queue_request(v, (n % 70) == 69);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      do
         @(negedge clock);
      while (pending_requests.size() != 0 || start || expected_terms.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (error_count == 0)
         $display("zeckendorf_decomposer_core verification clean");
      else
         $display("zeckendorf_decomposer_core verification failed");
      $finish;
   end

   initial begin
      #2ms;
      $display("zeckendorf_decomposer_core verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/zd_pkg.sv
rtl/zd_front.sv
rtl/zd_queue.sv
rtl/zd_back.sv
rtl/zeckendorf_decomposer_core.sv
bench/testbench.sv
